>>> src/odrc_pkg.sv
package odrc_pkg;

  // item kinds carried on the func field
  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_HOST = 2'd1,
    FUNC_OCC  = 2'd2
  } func_e;

  // host command mode bytes with a meaning
  localparam logic [7:0] MODE_OFF  = 8'd0;
  localparam logic [7:0] MODE_ON   = 8'd1;
  localparam logic [7:0] MODE_AUTO = 8'd2;

  // occupancy report codes
  localparam logic [7:0] OCC_VACATED  = 8'd0;
  localparam logic [7:0] OCC_OCCUPIED = 8'd1;

  // configuration register indexes
  localparam logic [3:0] CFG_TICKS_PER_SECOND = 4'd0;
  localparam logic [3:0] CFG_REPORT_INTERVAL  = 4'd1;

  localparam logic [15:0] TICKS_PER_SECOND_RST = 16'd100;
  localparam logic [15:0] REPORT_INTERVAL_RST  = 16'd600;

  localparam int unsigned CD_W = 14;
  localparam logic [CD_W-1:0] SECONDS_PER_MINUTE = 14'd60;

  typedef struct packed {
    logic            load;
    logic [7:0]      mode;
    logic [7:0]      delay_min;
    logic            cd_active;
    logic [CD_W-1:0] cd_sec;
    logic [15:0]     prescaler;
    logic [15:0]     report_sec;
  } state_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] mode_code;
    logic [7:0] delay_minutes_in;
    logic [7:0] occupancy_code;
  } item_t;

  typedef struct packed {
    logic       load_on;
    logic       report_due;
    logic [7:0] mode_now;
    logic [7:0] delay_minutes_now;
    logic       countdown_running;
  } result_t;

endpackage

>>> src/occupancy_delay_relay_controller.sv
// relay controller for one load with off, on and occupancy-driven auto modes.
// every accepted item (tick, host command or occupancy report) produces exactly
// one result item showing the controller state right after that item; ticks are
// prescaled to seconds by ticks_per_second, report_due pulses on the tick that
// completes a report interval, and in auto mode a vacated report starts a
// countdown of delay minutes times 60 seconds that switches the load off.
// an item passes through the input register, then the result register, on its
// way from acceptance to result, and one item is accepted every cycle; the only thing that
// holds the input back is a stalled result with a full input register.
// configuration writes are always ready and must be done while no item is
// in flight; indexes other than 0 and 1 are ignored.
module occupancy_delay_relay_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  mode_code_i,
  input  logic [7:0]  delay_minutes_in_i,
  input  logic [7:0]  occupancy_code_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        load_on_o,
  output logic        report_due_o,
  output logic [7:0]  mode_now_o,
  output logic [7:0]  delay_minutes_now_o,
  output logic        countdown_running_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // configuration registers
  logic [15:0] tps_q;
  logic [15:0] interval_q;

  // input register
  logic              s1_valid_q;
  odrc_pkg::item_t   s1_item_q;

  // controller state
  odrc_pkg::state_t  state_q;
  odrc_pkg::state_t  state_d;

  // result register
  logic              out_valid_q;
  odrc_pkg::result_t res_q;
  odrc_pkg::result_t res_d;

  logic out_free;  // result register can take a new item this cycle
  logic advance;   // input register item moves into the result register

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q      <= odrc_pkg::TICKS_PER_SECOND_RST;
      interval_q <= odrc_pkg::REPORT_INTERVAL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == odrc_pkg::CFG_TICKS_PER_SECOND) begin
        tps_q <= cfg_data_i;
      end else if (cfg_index_i == odrc_pkg::CFG_REPORT_INTERVAL) begin
        interval_q <= cfg_data_i;
      end
    end
  end

  // input register: loads whenever it is empty or its item leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || out_free) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((!s1_valid_q || out_free) && in_valid_i) begin
      s1_item_q.func             <= func_i;
      s1_item_q.mode_code        <= mode_code_i;
      s1_item_q.delay_minutes_in <= delay_minutes_in_i;
      s1_item_q.occupancy_code   <= occupancy_code_i;
    end
  end

  // next state and result for the item in the input register
  odrc_step u_step (
    .state_i            (state_q),
    .item_i             (s1_item_q),
    .ticks_per_second_i (tps_q),
    .report_interval_i  (interval_q),
    .state_o            (state_d),
    .result_o           (res_d)
  );

  // state only moves when its item is committed to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign load_on_o           = res_q.load_on;
  assign report_due_o        = res_q.report_due;
  assign mode_now_o          = res_q.mode_now;
  assign delay_minutes_now_o = res_q.delay_minutes_now;
  assign countdown_running_o = res_q.countdown_running;

`ifndef SYNTHESIS
  // state never moves without an item being committed
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without an item");

  // a waiting result matches the live state
  a_result_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (load_on_o == state_q.load &&
                     countdown_running_o == state_q.cd_active &&
                     mode_now_o == state_q.mode &&
                     delay_minutes_now_o == state_q.delay_min))
    else $error("result does not reflect controller state");

  // a report pulse leaves both second counters cleared
  a_pulse_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && report_due_o) |-> (state_q.report_sec == '0 &&
                                       state_q.prescaler == '0))
    else $error("report pulse without counter wrap");
`endif

endmodule

>>> src/odrc_step.sv
module odrc_step (
  input  odrc_pkg::state_t  state_i,
  input  odrc_pkg::item_t   item_i,
  input  logic [15:0]       ticks_per_second_i,
  input  logic [15:0]       report_interval_i,
  output odrc_pkg::state_t  state_o,
  output odrc_pkg::result_t result_o
);

  logic [15:0]               pre_next;
  logic [15:0]               rep_next;
  logic [odrc_pkg::CD_W-1:0] cd_next;
  logic [odrc_pkg::CD_W-1:0] cd_limit;
  logic                      pulse;

  assign pre_next = state_i.prescaler + 16'd1;
  assign rep_next = state_i.report_sec + 16'd1;
  assign cd_next  = state_i.cd_sec + 14'd1;
  // delay in seconds, at most 15300 so it fits the counter width
  assign cd_limit = odrc_pkg::CD_W'({6'd0, state_i.delay_min}) * odrc_pkg::SECONDS_PER_MINUTE;

  always_comb begin
    state_o = state_i;
    pulse   = 1'b0;
    unique case (item_i.func)
      odrc_pkg::FUNC_TICK: begin
        if (pre_next >= ticks_per_second_i) begin
          state_o.prescaler = '0;
          if (rep_next >= report_interval_i) begin
            state_o.report_sec = '0;
            pulse              = 1'b1;
          end else begin
            state_o.report_sec = rep_next;
          end
          if (state_i.cd_active) begin
            if (cd_next >= cd_limit) begin
              state_o.cd_active = 1'b0;
              state_o.cd_sec    = '0;
              state_o.load      = 1'b0;
            end else begin
              state_o.cd_sec = cd_next;
            end
          end
        end else begin
          state_o.prescaler = pre_next;
        end
      end
      odrc_pkg::FUNC_HOST: begin
        if (item_i.mode_code == odrc_pkg::MODE_OFF ||
            item_i.mode_code == odrc_pkg::MODE_AUTO) begin
          state_o.load      = 1'b0;
          state_o.cd_active = 1'b0;
        end else if (item_i.mode_code == odrc_pkg::MODE_ON) begin
          state_o.load      = 1'b1;
          state_o.cd_active = 1'b0;
        end
        state_o.mode      = item_i.mode_code;
        state_o.delay_min = item_i.delay_minutes_in;
      end
      odrc_pkg::FUNC_OCC: begin
        if (state_i.mode == odrc_pkg::MODE_AUTO) begin
          if (item_i.occupancy_code == odrc_pkg::OCC_OCCUPIED) begin
            state_o.cd_active = 1'b0;
            state_o.cd_sec    = '0;
            state_o.load      = 1'b1;
          end else if (item_i.occupancy_code == odrc_pkg::OCC_VACATED) begin
            state_o.cd_sec    = '0;
            state_o.cd_active = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign result_o.load_on           = state_o.load;
  assign result_o.report_due        = pulse;
  assign result_o.mode_now          = state_o.mode;
  assign result_o.delay_minutes_now = state_o.delay_min;
  assign result_o.countdown_running = state_o.cd_active;

endmodule
